[rtl/ftdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ftdt_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_LARGE = 2'd1,
		STATUS_SMALL = 2'd2
	} status_t;

	localparam int MAX_FRACTION_DIGITS = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int INT_W = 31;
	localparam int FRAC_W = 24;
	localparam int INT_DIGITS = 10;
	localparam int NDIG_W = 4;
	localparam int LEN_W = 5;

	// Biased exponent limits.
	localparam logic [7:0] EXP_BIAS_M1 = 8'd126;
	localparam logic [7:0] EXP_TOO_LARGE = 8'd158;
	localparam logic [7:0] EXP_TOO_SMALL = 8'd104;

	localparam logic [FRAC_W-1:0] HIDDEN_BIT = 24'h800000;

	// Reciprocal of ten for a 32-bit dividend: q = (v * RECIP10) >> 35.
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP10_SHIFT = 35;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// One classified number waiting between the front and the back.
	typedef struct packed {
		logic                sign_show;
		status_t             status;
		logic [INT_W-1:0]    int_val;
		logic [FRAC_W-1:0]   frac_rem;
		logic [LEN_W-1:0]    frac_digits;
	} job_t;

endpackage

`default_nettype wire

[rtl/ftdt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ftdt_front (
	input  wire logic [31:0] float_bits,
	output ftdt_pkg::job_t   job
);

	logic [7:0]                    expo;
	logic [ftdt_pkg::FRAC_W-1:0]   mant;
	logic [54:0]                   wide;
	logic [ftdt_pkg::FRAC_W-1:0]   rem;
	logic [4:0]                    tz;
	logic                          is_zero;

	assign expo = float_bits[30:23];
	assign mant = ftdt_pkg::HIDDEN_BIT | {1'b0, float_bits[22:0]};
	assign is_zero = (float_bits[30:0] == 31'd0);

	// Fixed point with 24 fraction bits: left shift for exponents of -1 and
	// above, truncating right shift below that.
	always_comb begin
		if (expo >= ftdt_pkg::EXP_BIAS_M1) begin
			wide = {31'd0, mant} << 5'(expo - ftdt_pkg::EXP_BIAS_M1);
		end else begin
			wide = {31'd0, mant >> 5'(ftdt_pkg::EXP_BIAS_M1 - expo)};
		end
	end

	assign rem = wide[ftdt_pkg::FRAC_W-1:0];

	// The fraction needs one digit per bit from its lowest set bit upward.
	always_comb begin
		tz = 5'd0;
		for (int i = ftdt_pkg::FRAC_W - 1; i >= 0; i--) begin
			if (rem[i]) begin
				tz = 5'(i);
			end
		end
	end

	always_comb begin
		job.sign_show   = 1'b0;
		job.status      = ftdt_pkg::STATUS_OK;
		job.int_val     = '0;
		job.frac_rem    = '0;
		job.frac_digits = 5'd1;
		if (is_zero) begin
			job.status = ftdt_pkg::STATUS_OK;
		end else if (expo >= ftdt_pkg::EXP_TOO_LARGE) begin
			job.status = ftdt_pkg::STATUS_LARGE;
		end else if (expo < ftdt_pkg::EXP_TOO_SMALL) begin
			job.status = ftdt_pkg::STATUS_SMALL;
		end else begin
			job.sign_show = float_bits[31];
			job.int_val   = wide[54:24];
			job.frac_rem  = rem;
			if (rem != '0) begin
				job.frac_digits = 5'(ftdt_pkg::FRAC_W) - tz;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/ftdt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ftdt_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire ftdt_pkg::job_t  wr_job,
	output logic                 q_full,
	input  wire logic            rd_en,
	output ftdt_pkg::job_t       rd_job,
	output logic                 q_empty
);

	ftdt_pkg::job_t                  mem [ftdt_pkg::QUEUE_DEPTH];
	logic [ftdt_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [ftdt_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [ftdt_pkg::QCNT_W-1:0]     count_q;

	assign q_full  = (count_q == ftdt_pkg::QCNT_W'(ftdt_pkg::QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_job  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == ftdt_pkg::QPTR_W'(ftdt_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == ftdt_pkg::QPTR_W'(ftdt_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/ftdt_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ftdt_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ftdt_pkg::job_t               job,
	input  wire logic                         job_empty,
	output logic                              job_take,
	output logic                              out_empty,
	input  wire logic                         out_pop,
	output logic [7:0]                        out_char,
	output logic                              out_last,
	output logic [1:0]                        out_status,
	output logic [ftdt_pkg::LEN_W-1:0]        out_len
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_INT,
		ST_POINT,
		ST_FRAC
	} state_t;

	state_t                          state_q;
	logic [ftdt_pkg::INT_W-1:0]      int_q;
	logic [ftdt_pkg::FRAC_W-1:0]     rem_q;
	logic [ftdt_pkg::NDIG_W-1:0]     nd_q;
	logic [ftdt_pkg::NDIG_W-1:0]     rd_q;
	logic                            sign_q;
	ftdt_pkg::status_t               status_q;
	logic [ftdt_pkg::LEN_W-1:0]      nfrac_q;
	logic [ftdt_pkg::LEN_W-1:0]      total_q;
	logic [ftdt_pkg::LEN_W-1:0]      cnt_q;
	logic [3:0]                      digits [ftdt_pkg::INT_DIGITS];

	logic                            out_valid_q;
	logic [7:0]                      char_q;
	logic                            last_q;
	logic [1:0]                      ostat_q;
	logic [ftdt_pkg::LEN_W-1:0]      olen_q;

	logic                            slot_free;
	logic                            emit_now;
	logic [62:0]                     prod;
	logic [ftdt_pkg::INT_W-1:0]      quot;
	logic [ftdt_pkg::INT_W-1:0]      rem10;
	logic [3:0]                      int_digit;
	logic [ftdt_pkg::NDIG_W-1:0]     nd_final;
	logic [27:0]                     frac_prod;
	logic                            is_last;
	logic                            store_we;
	logic [ftdt_pkg::NDIG_W-1:0]     store_idx;
	logic [3:0]                      store_val;

	assign slot_free = !out_valid_q || out_pop;
	assign job_take  = (state_q == ST_IDLE) && !job_empty;
	assign emit_now  = slot_free && (state_q == ST_SIGN || state_q == ST_INT ||
	                                 state_q == ST_POINT || state_q == ST_FRAC);

	// One decimal digit per cycle: divide by ten through the reciprocal.
	assign prod      = 63'(int_q) * 63'(ftdt_pkg::RECIP10);
	assign quot      = ftdt_pkg::INT_W'(prod >> ftdt_pkg::RECIP10_SHIFT);
	assign rem10     = int_q - ((quot << 3) + (quot << 1));
	assign int_digit = rem10[3:0];
	assign nd_final  = (nd_q == '0) ? ftdt_pkg::NDIG_W'(1) : nd_q;

	assign frac_prod = 28'(rem_q) * 28'd10;
	assign is_last   = ((cnt_q + 1'b1) == total_q);

	always_comb begin
		store_we  = 1'b0;
		store_idx = nd_q;
		store_val = int_digit;
		if (state_q == ST_CONV) begin
			if (int_q != '0) begin
				store_we = 1'b1;
			end else if (nd_q == '0) begin
				store_we  = 1'b1;
				store_val = 4'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			digits[store_idx] <= store_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			int_q       <= '0;
			rem_q       <= '0;
			nd_q        <= '0;
			rd_q        <= '0;
			sign_q      <= 1'b0;
			status_q    <= ftdt_pkg::STATUS_OK;
			nfrac_q     <= '0;
			total_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
			ostat_q     <= '0;
			olen_q      <= '0;
		end else begin
			if (out_pop && !emit_now) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						int_q    <= job.int_val;
						rem_q    <= job.frac_rem;
						sign_q   <= job.sign_show;
						status_q <= job.status;
						nfrac_q  <= job.frac_digits;
						nd_q     <= '0;
						cnt_q    <= '0;
						state_q  <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (int_q != '0) begin
						int_q <= quot;
						nd_q  <= nd_q + 1'b1;
					end else begin
						total_q <= ftdt_pkg::LEN_W'(sign_q) + ftdt_pkg::LEN_W'(nd_final)
						           + ftdt_pkg::LEN_W'(1) + nfrac_q;
						rd_q    <= nd_final - 1'b1;
						state_q <= sign_q ? ST_SIGN : ST_INT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						char_q      <= ftdt_pkg::CHAR_MINUS;
						last_q      <= is_last;
						cnt_q       <= cnt_q + 1'b1;
						state_q     <= ST_INT;
					end
				end
				ST_INT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						char_q      <= ftdt_pkg::CHAR_ZERO + 8'(digits[rd_q]);
						last_q      <= is_last;
						cnt_q       <= cnt_q + 1'b1;
						if (rd_q == '0) begin
							state_q <= ST_POINT;
						end else begin
							rd_q <= rd_q - 1'b1;
						end
					end
				end
				ST_POINT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						char_q      <= ftdt_pkg::CHAR_POINT;
						last_q      <= is_last;
						cnt_q       <= cnt_q + 1'b1;
						state_q     <= ST_FRAC;
					end
				end
				ST_FRAC: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						char_q      <= ftdt_pkg::CHAR_ZERO + 8'(frac_prod[27:24]);
						last_q      <= is_last;
						cnt_q       <= cnt_q + 1'b1;
						rem_q       <= frac_prod[23:0];
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Status and length are loaded with every character, so a character
			// still waiting keeps the values of its own number.
			if (emit_now) begin
				ostat_q <= status_q;
				olen_q  <= (status_q == ftdt_pkg::STATUS_OK) ? total_q : '0;
			end
		end
	end

	assign out_empty  = !out_valid_q;
	assign out_char   = char_q;
	assign out_last   = last_q;
	assign out_status = ostat_q;
	assign out_len    = olen_q;

endmodule

`default_nettype wire

[rtl/float_to_decimal_text.sv]
`timescale 1ns / 1ps
`default_nettype none

// Converts IEEE 754 single-precision words into decimal ASCII text.
// Input side is a queue: a word on float_bits is taken when push is high and
// full is low. Result side is a queue too: while empty is low the oldest
// character sits on character, last_char, status and text_length, and it is
// taken when pop is high. Each number yields an optional '-', the integer
// digits, a '.', and the fraction digits without trailing zeros; last_char
// marks its final character. Zero, too-large and too-small inputs give "0.0",
// the latter two with a non-zero status and a text_length of zero.
// The front classifies each word and aligns it in the cycle it is taken, and
// a two-entry queue holds classified numbers for the back. The back loads a
// number, runs the divide-by-ten unit once per integer digit plus one closing
// step (a zero integer part needs only the closing step), and then emits the
// characters; it takes the next number only after the last character. The
// first character is registered after the queue, the load, the integer
// conversion and the closing step. A stalled receiver holds the character
// register, and the back then waits; the front keeps accepting until the
// queue is full.
// Reset empties the queue and the output register and idles the back.

module float_to_decimal_text (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] float_bits,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       character,
	output logic             last_char,
	output logic [1:0]       status,
	output logic [4:0]       text_length
);

	ftdt_pkg::job_t  front_job;
	ftdt_pkg::job_t  back_job;
	logic            q_full;
	logic            q_empty;
	logic            job_take;

	// Classification and alignment of the incoming word.
	ftdt_front u_front (
		.float_bits (float_bits),
		.job        (front_job)
	);

	// Short queue that lets the front run ahead of the character output.
	ftdt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !q_full),
		.wr_job  (front_job),
		.q_full  (q_full),
		.rd_en   (job_take),
		.rd_job  (back_job),
		.q_empty (q_empty)
	);

	assign full = q_full;

	// Digit conversion and character emission.
	ftdt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (back_job),
		.job_empty  (q_empty),
		.job_take   (job_take),
		.out_empty  (empty),
		.out_pop    (pop),
		.out_char   (character),
		.out_last   (last_char),
		.out_status (status),
		.out_len    (text_length)
	);

endmodule

`default_nettype wire
